@@ rtl/charge_sharing_lif_neuron_defines.svh @@
// Assertion macros used by the neuron sequencer.
`ifndef CHARGE_SHARING_LIF_NEURON_DEFINES_SVH
`define CHARGE_SHARING_LIF_NEURON_DEFINES_SVH

// Check that a condition implies another one in the same cycle.
`define CSLIF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another one in the next cycle.
`define CSLIF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/cslif_pkg.sv @@
// Shared types, widths and register codes of the charge-sharing neuron.
package cslif_pkg;

	localparam int NUM_SYNAPSES = 8;
	localparam int W_W          = 8;
	localparam int V_W          = 16;
	localparam int Q_W          = 16;
	localparam int CSTAT_W      = V_W + $clog2(NUM_SYNAPSES + 1);
	localparam int WSUM_W       = W_W + $clog2(NUM_SYNAPSES + 1);
	localparam int CTOT_W       = V_W + WSUM_W + 1;
	localparam int PV_W         = CSTAT_W + V_W;
	localparam int NUMLO_W      = PV_W + V_W;
	localparam int US_W         = 2 * V_W;
	localparam int CH_W         = US_W + WSUM_W;
	localparam int DVD_W        = CTOT_W + Q_W;
	localparam int CNT_W        = $clog2(Q_W);
	localparam int IDX_W        = 3;
	localparam int DATA_W       = 64;

	typedef enum logic [IDX_W-1:0] {
		REG_THRESHOLD  = 3'd0,
		REG_SUPPLY     = 3'd1,
		REG_REFRACTORY = 3'd2,
		REG_NEURON_CAP = 3'd3,
		REG_UNIT_CAP   = 3'd4,
		REG_PARA_CAP   = 3'd5,
		REG_DECAY      = 3'd6,
		REG_WEIGHTS    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [V_W-1:0]    thr;
		logic [V_W-1:0]    vdd;
		logic [V_W-1:0]    refr_ticks;
		logic [V_W-1:0]    ncap;
		logic [V_W-1:0]    ucap;
		logic [V_W-1:0]    pcap;
		logic [V_W-1:0]    decay;
		logic [DATA_W-1:0] weights;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic sum;
		logic chk;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic refr_busy;
		logic ctot_zero;
	} stat_t;

endpackage

@@ rtl/cslif_cfg.sv @@
// Configuration register file of the neuron.
module cslif_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [cslif_pkg::IDX_W-1:0]  cfg_index,
	input  logic [cslif_pkg::DATA_W-1:0] cfg_data,
	output cslif_pkg::cfg_t           cfg
);
	import cslif_pkg::*;

	cfg_t cfg_q;

	// accept a word every cycle
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr        <= 16'd4096;
			cfg_q.vdd        <= 16'd4096;
			cfg_q.refr_ticks <= 16'd0;
			cfg_q.ncap       <= 16'd100;
			cfg_q.ucap       <= 16'd1;
			cfg_q.pcap       <= 16'd0;
			cfg_q.decay      <= 16'hFFFF;
			cfg_q.weights    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_THRESHOLD:  cfg_q.thr        <= cfg_data[V_W-1:0];
				REG_SUPPLY:     cfg_q.vdd        <= cfg_data[V_W-1:0];
				REG_REFRACTORY: cfg_q.refr_ticks <= cfg_data[V_W-1:0];
				REG_NEURON_CAP: cfg_q.ncap       <= cfg_data[V_W-1:0];
				REG_UNIT_CAP:   cfg_q.ucap       <= cfg_data[V_W-1:0];
				REG_PARA_CAP:   cfg_q.pcap       <= cfg_data[V_W-1:0];
				REG_DECAY:      cfg_q.decay      <= cfg_data[V_W-1:0];
				REG_WEIGHTS:    cfg_q.weights    <= cfg_data;
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

endmodule

@@ rtl/cslif_dp.sv @@
// Datapath of the neuron: products, dividend, restoring divider and state.
module cslif_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cslif_pkg::cfg_t                   cfg,
	input  cslif_pkg::cmd_t                   cmd,
	output cslif_pkg::stat_t                  stat,
	input  logic [cslif_pkg::NUM_SYNAPSES-1:0] spike_mask,
	output logic                              fired,
	output logic [cslif_pkg::V_W-1:0]         membrane_voltage,
	output logic                              in_refractory,
	output logic                              zero_capacitance
);
	import cslif_pkg::*;

	// neuron state
	logic [V_W-1:0]     volt_q;
	logic [V_W-1:0]     left_q;
	// working registers
	logic               refr_q;
	logic [CSTAT_W-1:0] cstat_q;
	logic [WSUM_W-1:0]  wsum_q;
	logic [CTOT_W-1:0]  ctot_q;
	logic [PV_W-1:0]    pv_q;
	logic [US_W-1:0]    us_q;
	logic [NUMLO_W-1:0] numlo_q;
	logic [CH_W-1:0]    ch_q;
	logic [DVD_W-1:0]   dvd_q;
	logic               ovf_q;
	logic [CTOT_W-1:0]  rem_q;
	logic [Q_W-1:0]     dlo_q;
	logic [Q_W-1:0]     quo_q;
	// result word
	logic               fired_q;
	logic [V_W-1:0]     mv_q;
	logic               refo_q;
	logic               zcap_q;

	logic [WSUM_W-1:0]  wsum_c;
	logic [CTOT_W:0]    trial_c;
	logic [Q_W-1:0]     q_c;

	assign stat.refr_busy = (left_q != '0);
	assign stat.ctot_zero = (ctot_q == '0);

	// sum the weights of the active synapses
	always_comb begin
		wsum_c = '0;
		for (int i = 0; i < NUM_SYNAPSES; i++) begin
			if (spike_mask[i])
				wsum_c = wsum_c + WSUM_W'(cfg.weights[W_W*i +: W_W]);
		end
	end

	assign trial_c = {rem_q, dlo_q[Q_W-1]};
	assign q_c     = ovf_q ? {Q_W{1'b1}} : quo_q;

	// advance the arithmetic sequence
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			refr_q  <= (left_q != '0);
			wsum_q  <= wsum_c;
			cstat_q <= CSTAT_W'(cfg.ncap) + CSTAT_W'(cfg.pcap) * CSTAT_W'(NUM_SYNAPSES);
		end
		if (cmd.mul1) begin
			ctot_q <= CTOT_W'(cstat_q) + CTOT_W'(cfg.ucap) * CTOT_W'(wsum_q);
			pv_q   <= PV_W'(cstat_q) * PV_W'(volt_q);
			us_q   <= US_W'(cfg.ucap) * US_W'(cfg.vdd);
		end
		if (cmd.mul2) begin
			numlo_q <= NUMLO_W'(pv_q) * NUMLO_W'(cfg.decay);
			ch_q    <= CH_W'(us_q) * CH_W'(wsum_q);
		end
		if (cmd.sum)
			dvd_q <= DVD_W'(ch_q) + DVD_W'(numlo_q[NUMLO_W-1:Q_W]);
		if (cmd.chk) begin
			ovf_q <= (dvd_q >= {ctot_q, {Q_W{1'b0}}});
			rem_q <= dvd_q[DVD_W-1 -: CTOT_W];
			dlo_q <= dvd_q[Q_W-1:0];
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			dlo_q <= {dlo_q[Q_W-2:0], 1'b0};
			if (trial_c >= {1'b0, ctot_q}) begin
				rem_q <= CTOT_W'(trial_c - {1'b0, ctot_q});
				quo_q <= {quo_q[Q_W-2:0], 1'b1};
			end else begin
				rem_q <= trial_c[CTOT_W-1:0];
				quo_q <= {quo_q[Q_W-2:0], 1'b0};
			end
		end
	end

	// update the neuron state at the end of a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_q <= '0;
			left_q <= '0;
		end else if (cmd.finish) begin
			if (refr_q) begin
				volt_q <= '0;
				left_q <= left_q - 1'b1;
			end else if (ctot_q == '0) begin
				volt_q <= volt_q;
			end else if (q_c >= cfg.thr) begin
				volt_q <= '0;
				left_q <= cfg.refr_ticks;
			end else begin
				volt_q <= q_c;
			end
		end
	end

	// load the result word
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (refr_q) begin
				{fired_q, mv_q, refo_q, zcap_q} <= {1'b0, {V_W{1'b0}}, 1'b1, 1'b0};
			end else if (ctot_q == '0) begin
				{fired_q, mv_q, refo_q, zcap_q} <= {1'b0, volt_q, 1'b0, 1'b1};
			end else if (q_c >= cfg.thr) begin
				{fired_q, mv_q, refo_q, zcap_q} <= {1'b1, {V_W{1'b0}}, 1'b0, 1'b0};
			end else begin
				{fired_q, mv_q, refo_q, zcap_q} <= {1'b0, q_c, 1'b0, 1'b0};
			end
		end
	end

	assign fired            = fired_q;
	assign membrane_voltage = mv_q;
	assign in_refractory    = refo_q;
	assign zero_capacitance = zcap_q;

endmodule

@@ rtl/cslif_ctrl.sv @@
// Sequencer of the neuron: steps the datapath through one tick.
`include "charge_sharing_lif_neuron_defines.svh"

module cslif_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  cslif_pkg::stat_t  stat,
	output cslif_pkg::cmd_t   cmd
);
	import cslif_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_SUM,
		ST_CHK,
		ST_DIV,
		ST_FIN
	} state_t;

	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(Q_W - 1);

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             can_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign can_load  = !out_valid_q || !out_stall;

	// decode commands from the state
	assign cmd.load     = (state_q == ST_IDLE) && in_valid;
	assign cmd.mul1     = (state_q == ST_MUL1);
	assign cmd.mul2     = (state_q == ST_MUL2);
	assign cmd.sum      = (state_q == ST_SUM);
	assign cmd.chk      = (state_q == ST_CHK);
	assign cmd.div_step = (state_q == ST_DIV);
	assign cmd.finish   = (state_q == ST_FIN) && can_load;

	// hold state, step counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= stat.refr_busy ? ST_FIN : ST_MUL1;
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= stat.ctot_zero ? ST_FIN : ST_SUM;
				ST_SUM:  state_q <= ST_CHK;
				ST_CHK: begin
					state_q <= ST_DIV;
					cnt_q   <= '0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_STEP)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (can_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`CSLIF_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0(cmd), "more than one datapath command")
	`CSLIF_ASSERT_SAME(a_no_overwrite, cmd.finish, !(out_valid_q && out_stall), "result overwritten")
	`CSLIF_ASSERT_NEXT(a_refr_skip, cmd.load && stat.refr_busy, state_q == ST_FIN, "refractory tick ran arithmetic")
	`CSLIF_ASSERT_NEXT(a_div_end, state_q == ST_DIV && cnt_q == LAST_STEP, state_q == ST_FIN, "divider overran")

endmodule

@@ rtl/charge_sharing_lif_neuron.sv @@
// Top level of the charge-sharing leaky integrate-and-fire neuron.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | spike_mask
//  out     | out_valid / out_stall| fired, membrane_voltage, in_refractory,
//          |                      | zero_capacitance
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A normal tick runs MUL1, MUL2, SUM, CHK, the 16-step restoring divider and
// FIN before the next accept; the divider is most of it. A refractory tick
// jumps from accept to FIN, one with zero total capacitance from MUL2 to FIN.
// Reset clears the neuron voltage and refractory counter and loads the register
// defaults. A stalled result holds the sequencer in its final step, while the
// previous result waits in the output register as the next tick is worked on.
module charge_sharing_lif_neuron (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [cslif_pkg::NUM_SYNAPSES-1:0] spike_mask,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               fired,
	output logic [cslif_pkg::V_W-1:0]          membrane_voltage,
	output logic                               in_refractory,
	output logic                               zero_capacitance,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cslif_pkg::IDX_W-1:0]        cfg_index,
	input  logic [cslif_pkg::DATA_W-1:0]       cfg_data
);
	import cslif_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	cslif_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cslif_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.cmd              (cmd),
		.stat             (stat),
		.spike_mask       (spike_mask),
		.fired            (fired),
		.membrane_voltage (membrane_voltage),
		.in_refractory    (in_refractory),
		.zero_capacitance (zero_capacitance)
	);

	cslif_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

endmodule
